FILE: hw/rtl/twra_pkg.sv
// shared types and constants for the three-wire register access master
// no dependencies; used by every module of the block
`default_nettype none

package twra_pkg;

    // serial frame geometry
    localparam int DATA_BITS  = 16;
    localparam int ADDR_BITS  = 8;
    localparam int SHIFT_BITS = ADDR_BITS + DATA_BITS;
    localparam int BIT_IDX_W  = $clog2(SHIFT_BITS);
    localparam int ADDR_W     = 7;
    localparam int TICK_W     = 8;

    // stream word widths
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;

    localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 8'd10;
    localparam int                QUEUE_DEPTH_DEF   = 4;

    // request codes on the input kind lane
    localparam logic [S_TUSER_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [S_TUSER_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [S_TUSER_W-1:0] CMD_READ  = 2'd2;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_SEND = 5'b00010,
        PH_GAP  = 5'b00100,
        PH_RECV = 5'b01000,
        PH_DONE = 5'b10000
    } phase_t;

    // one classified word waiting for the engine
    typedef struct packed {
        kind_t                 kind;
        logic [SHIFT_BITS-1:0] load_word;
        logic                  sda_in;
    } item_t;

    // pin levels and status of one tick
    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic                 done_res;
        logic                 busy_res;
        logic                 cs_n;
        logic                 sda_drive;
        logic                 sda_out;
        logic                 scl;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/three_wire_register_access_master_unit.sv
// three-wire register access master: one input word is one tick of the serial engine
// path from input accept to result valid: a queue slot, then the result register
// throughput: 1 word per cycle while the output is not stalled; the engine advances one tick per popped word
// reset: synchronous active-low aresetn; engine idle, no result valid, half_period 10, queue empty
// depends on twra_pkg, twra_front, twra_queue, twra_engine
`default_nettype none

module three_wire_register_access_master_unit #(
    parameter int QUEUE_DEPTH = twra_pkg::QUEUE_DEPTH_DEF   // words between front and engine
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // half_period register write
    input  wire logic                           cfg_we,
    input  wire logic [twra_pkg::TICK_W-1:0]    cfg_wdata,

    // request words
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // reg_addr[6:0], write_data[22:7], sda_in[23]
    input  wire logic [twra_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [twra_pkg::S_TUSER_W-1:0] s_axis_tuser,

    // pin and status words
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // scl[0], sda_out[1], sda_drive[2], cs_n[3], busy_res[4], read_data[20:5], zero[23:21]
    output logic [twra_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // done_res: end of an access
    output logic                                m_axis_tlast
);

    twra_pkg::item_t front_item;
    twra_pkg::item_t eng_item;
    twra_pkg::res_t  eng_res;
    logic            front_push;
    logic            q_ready;
    logic            q_valid;
    logic            q_pop;

    // front end: decode the request kind and prepare the shift word
    twra_front u_front (
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .q_ready  (q_ready),
        .q_push   (front_push),
        .q_item   (front_item)
    );

    // decoupling queue so input and output stalls stay independent
    twra_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_push),
        .push_item  (front_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (eng_item)
    );

    // serial engine with its output register; pops a word whenever the
    // result register is free or being drained
    twra_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (eng_item),
        .q_pop     (q_pop),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_res     (eng_res)
    );

    // pack the result word, lowest field first
    assign m_axis_tdata = {3'b000, eng_res.read_data, eng_res.busy_res, eng_res.cs_n,
                           eng_res.sda_drive, eng_res.sda_out, eng_res.scl};
    assign m_axis_tlast = eng_res.done_res;

endmodule

`default_nettype wire

FILE: hw/rtl/twra_front.sv
// front end: decodes the request kind and builds the left-aligned shift word
// depends on twra_pkg
`default_nettype none

module twra_front (
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [twra_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [twra_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic                           q_ready,
    output logic                                q_push,
    output twra_pkg::item_t                     q_item
);

    logic [twra_pkg::ADDR_W-1:0]    reg_addr;
    logic [twra_pkg::DATA_BITS-1:0] write_data;

    assign reg_addr   = s_tdata[twra_pkg::ADDR_W-1:0];
    assign write_data = s_tdata[twra_pkg::ADDR_W +: twra_pkg::DATA_BITS];

    assign s_tready = q_ready;
    assign q_push   = s_tvalid & q_ready;

    always_comb begin
        q_item.sda_in = s_tdata[twra_pkg::ADDR_W + twra_pkg::DATA_BITS];
        case (s_tuser)
            twra_pkg::CMD_WRITE: begin
                q_item.kind      = twra_pkg::KIND_WRITE;
                q_item.load_word = {1'b0, reg_addr, write_data};
            end
            twra_pkg::CMD_READ: begin
                // address byte with the read flag, left-aligned
                q_item.kind      = twra_pkg::KIND_READ;
                q_item.load_word = {1'b1, reg_addr, {twra_pkg::DATA_BITS{1'b0}}};
            end
            default: begin
                q_item.kind      = twra_pkg::KIND_TICK;
                q_item.load_word = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/twra_queue.sv
// short word queue between front end and serial engine
// depends on twra_pkg
`default_nettype none

module twra_queue #(
    parameter int DEPTH = twra_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire twra_pkg::item_t push_item,
    output logic                 push_ready,
    input  wire logic            pop,
    output logic                 pop_valid,
    output twra_pkg::item_t      pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    twra_pkg::item_t  slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/twra_engine.sv
// back end: bit-serial three-wire engine, one tick per word, registered result
// depends on twra_pkg
`default_nettype none

module twra_engine (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [twra_pkg::TICK_W-1:0] cfg_wdata,
    input  wire logic                        q_valid,
    input  wire twra_pkg::item_t             q_item,
    output logic                             q_pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output twra_pkg::res_t                   m_res
);

    localparam int BW = twra_pkg::BIT_IDX_W;
    localparam int TW = twra_pkg::TICK_W;
    localparam logic [BW-1:0] WR_LAST   = BW'(twra_pkg::SHIFT_BITS - 1);
    localparam logic [BW-1:0] RD_LAST   = BW'(twra_pkg::ADDR_BITS - 1);
    localparam logic [BW-1:0] RECV_LAST = BW'(twra_pkg::DATA_BITS - 1);

    logic [TW-1:0]                   half_period_reg;
    twra_pkg::phase_t                phase_reg, phase_next;
    logic [BW-1:0]                   bit_index_reg, bit_index_next;
    logic [TW-1:0]                   tick_reg, tick_next;
    logic [twra_pkg::SHIFT_BITS-1:0] out_shift_reg, out_shift_next;
    logic [twra_pkg::DATA_BITS-1:0]  in_shift_reg, in_shift_next;
    logic                            is_read_reg, is_read_next;
    logic                            clk_lvl_reg, clk_lvl_next;
    logic                            m_valid_reg;
    twra_pkg::res_t                  m_res_reg, res;

    logic [TW-1:0] hp;
    logic [TW-1:0] tick_inc;
    logic          half_end;
    logic [BW-1:0] last_bit;
    logic [BW-1:0] send_idx;
    logic          step;

    assign step     = q_valid & (~m_valid_reg | m_ready);
    assign q_pop    = step;
    assign m_valid  = m_valid_reg;
    assign m_res    = m_res_reg;
    assign hp       = (half_period_reg == '0) ? TW'(1) : half_period_reg;

    always_comb begin
        phase_next     = phase_reg;
        bit_index_next = bit_index_reg;
        tick_next      = tick_reg;
        out_shift_next = out_shift_reg;
        in_shift_next  = in_shift_reg;
        is_read_next   = is_read_reg;
        clk_lvl_next   = clk_lvl_reg;

        res           = '0;
        res.cs_n      = 1'b1;

        // start of an access, only from idle
        if (phase_reg == twra_pkg::PH_IDLE && q_item.kind != twra_pkg::KIND_TICK) begin
            is_read_next   = (q_item.kind == twra_pkg::KIND_READ);
            out_shift_next = q_item.load_word;
            in_shift_next  = '0;
            bit_index_next = '0;
            tick_next      = '0;
            clk_lvl_next   = 1'b0;
            phase_next     = twra_pkg::PH_SEND;
        end

        tick_inc = tick_next + 1'b1;
        half_end = (tick_inc >= hp);
        last_bit = is_read_next ? RD_LAST : WR_LAST;
        send_idx = WR_LAST - bit_index_next;

        case (phase_next)
            twra_pkg::PH_SEND: begin
                res.scl       = clk_lvl_next;
                res.sda_out   = out_shift_next[send_idx];
                res.sda_drive = 1'b1;
                res.cs_n      = 1'b0;
                res.busy_res  = 1'b1;
                tick_next     = half_end ? '0 : tick_inc;
                if (half_end) begin
                    clk_lvl_next = ~clk_lvl_next;
                    if (clk_lvl_next == 1'b0) begin
                        // falling edge closes the bit
                        if (bit_index_next == last_bit) begin
                            bit_index_next = '0;
                            phase_next     = is_read_next ? twra_pkg::PH_GAP
                                                          : twra_pkg::PH_DONE;
                        end else begin
                            bit_index_next = bit_index_next + 1'b1;
                        end
                    end
                end
            end
            twra_pkg::PH_GAP: begin
                // last address bit stays on the pin during turnaround
                res.sda_out   = out_shift_next[twra_pkg::DATA_BITS];
                res.sda_drive = 1'b1;
                res.cs_n      = 1'b0;
                res.busy_res  = 1'b1;
                tick_next     = half_end ? '0 : tick_inc;
                if (half_end) begin
                    clk_lvl_next   = 1'b0;
                    bit_index_next = '0;
                    phase_next     = twra_pkg::PH_RECV;
                end
            end
            twra_pkg::PH_RECV: begin
                res.scl      = clk_lvl_next;
                res.cs_n     = 1'b0;
                res.busy_res = 1'b1;
                if (clk_lvl_next && tick_next == '0) begin
                    in_shift_next = {in_shift_next[twra_pkg::DATA_BITS-2:0], q_item.sda_in};
                end
                tick_next = half_end ? '0 : tick_inc;
                if (half_end) begin
                    clk_lvl_next = ~clk_lvl_next;
                    if (clk_lvl_next == 1'b0) begin
                        if (bit_index_next == RECV_LAST) begin
                            bit_index_next = '0;
                            phase_next     = twra_pkg::PH_DONE;
                        end else begin
                            bit_index_next = bit_index_next + 1'b1;
                        end
                    end
                end
            end
            twra_pkg::PH_DONE: begin
                res.busy_res  = 1'b1;
                res.done_res  = 1'b1;
                res.read_data = is_read_next ? in_shift_next : '0;
                tick_next     = '0;
                clk_lvl_next  = 1'b0;
                phase_next    = twra_pkg::PH_IDLE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= twra_pkg::HALF_PERIOD_RESET;
        end else if (cfg_we) begin
            half_period_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= twra_pkg::PH_IDLE;
            bit_index_reg <= '0;
            tick_reg      <= '0;
            out_shift_reg <= '0;
            in_shift_reg  <= '0;
            is_read_reg   <= 1'b0;
            clk_lvl_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (step) begin
                phase_reg     <= phase_next;
                bit_index_reg <= bit_index_next;
                tick_reg      <= tick_next;
                out_shift_reg <= out_shift_next;
                in_shift_reg  <= in_shift_next;
                is_read_reg   <= is_read_next;
                clk_lvl_reg   <= clk_lvl_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_res_reg <= res;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_three_wire_register_access_master_unit.sv
// testbench for the three-wire register access master: sends one tick word per cycle when not
// held, predicts every pin word with a cycle model of the serial engine, checks each field
// depends on twra_pkg and three_wire_register_access_master_unit
`timescale 1ns / 100ps

module tb_three_wire_register_access_master_unit;
    import twra_pkg::*;

    localparam logic [S_TUSER_W-1:0] CMD_UNUSED = 2'd3;  // treated as a plain tick
    localparam int                   SDA_LOW    = 0;
    localparam int                   SDA_HIGH   = 1;
    localparam int                   SDA_RANDOM = 2;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [TICK_W-1:0]    cfg_wdata     = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    three_wire_register_access_master_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 aclk = ~aclk;

    // pin words still owed by the block, oldest first
    res_t expected_pins[$];
    int   words_sent     = 0;
    int   words_checked  = 0;
    int   mismatch_count = 0;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;

    // ------------------------------------------------------------------
    // cycle model of the serial engine
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]     hp_reg;
    phase_t                eng_phase;
    int                    bit_pos;
    logic [TICK_W-1:0]     tick_cnt;
    logic [SHIFT_BITS-1:0] tx_shift;
    logic [DATA_BITS-1:0]  rx_shift;
    logic                  rd_access;
    logic                  clk_lvl;

    task automatic reset_model();
        hp_reg    = HALF_PERIOD_RESET;
        eng_phase = PH_IDLE;
        bit_pos   = 0;
        tick_cnt  = '0;
        tx_shift  = '0;
        rx_shift  = '0;
        rd_access = 1'b0;
        clk_lvl   = 1'b0;
    endtask

    // a zero half period runs like a half period of one
    function automatic logic [TICK_W-1:0] eff_half_period();
        return (hp_reg == '0) ? 8'd1 : hp_reg;
    endfunction

    // one tick of the half-period timer, true when a whole serial bit has ended
    function automatic bit advance_clock();
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt >= eff_half_period()) begin
            tick_cnt = '0;
            if (!clk_lvl) begin
                clk_lvl = 1'b1;
                return 1'b0;
            end
            clk_lvl = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // pin levels for one tick word, advancing the model state
    function automatic res_t predict_tick(input logic [S_TUSER_W-1:0] cmd,
                                          input logic [ADDR_W-1:0]    addr,
                                          input logic [DATA_BITS-1:0] wdata,
                                          input logic                 sda);
        res_t pins;
        int   nbits;
        pins      = '0;
        pins.cs_n = 1'b1;

        // a request only starts an access from idle
        if (eng_phase == PH_IDLE && (cmd == CMD_WRITE || cmd == CMD_READ)) begin
            rd_access = (cmd == CMD_READ);
            tx_shift  = rd_access ? {16'd0, 1'b1, addr} : {1'b0, addr, wdata};
            rx_shift  = '0;
            bit_pos   = 0;
            tick_cnt  = '0;
            clk_lvl   = 1'b0;
            eng_phase = PH_SEND;
        end

        nbits = rd_access ? ADDR_BITS : SHIFT_BITS;

        case (eng_phase)
            PH_SEND: begin
                pins.scl       = clk_lvl;
                pins.sda_out   = tx_shift[nbits - 1 - bit_pos];
                pins.sda_drive = 1'b1;
                pins.cs_n      = 1'b0;
                pins.busy_res  = 1'b1;
                if (advance_clock()) begin
                    bit_pos++;
                    if (bit_pos >= nbits) begin
                        bit_pos   = 0;
                        tick_cnt  = '0;
                        eng_phase = rd_access ? PH_GAP : PH_DONE;
                    end
                end
            end
            PH_GAP: begin
                // clock parked low, last address bit still on the pin
                pins.sda_out   = tx_shift[0];
                pins.sda_drive = 1'b1;
                pins.cs_n      = 1'b0;
                pins.busy_res  = 1'b1;
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= eff_half_period()) begin
                    tick_cnt  = '0;
                    clk_lvl   = 1'b0;
                    bit_pos   = 0;
                    eng_phase = PH_RECV;
                end
            end
            PH_RECV: begin
                pins.scl      = clk_lvl;
                pins.cs_n     = 1'b0;
                pins.busy_res = 1'b1;
                // sample on the first high tick of each bit
                if (clk_lvl && tick_cnt == '0)
                    rx_shift = {rx_shift[DATA_BITS-2:0], sda};
                if (advance_clock()) begin
                    bit_pos++;
                    if (bit_pos >= DATA_BITS) begin
                        bit_pos   = 0;
                        eng_phase = PH_DONE;
                    end
                end
            end
            PH_DONE: begin
                // chip select back up, still busy so a request here is dropped
                pins.busy_res = 1'b1;
                pins.done_res = 1'b1;
                if (rd_access)
                    pins.read_data = rx_shift;
                tick_cnt  = '0;
                clk_lvl   = 1'b0;
                eng_phase = PH_IDLE;
            end
            default: ;
        endcase
        return pins;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offers one word, optionally after idle cycles, and books its pin word once taken
    task automatic send_word(input logic [S_TUSER_W-1:0] cmd,
                             input logic [ADDR_W-1:0]    addr,
                             input logic [DATA_BITS-1:0] wdata,
                             input logic                 sda);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {sda, wdata, addr};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        expected_pins.push_back(predict_tick(cmd, addr, wdata, sda));
        words_sent++;
    endtask

    task automatic send_random(input logic [S_TUSER_W-1:0] cmd);
        send_word(cmd, ADDR_W'($urandom_range(127)), DATA_BITS'($urandom_range(16'hffff)),
                  logic'($urandom_range(1)));
    endtask

    function automatic logic pick_sda(input int fill);
        return (fill == SDA_RANDOM) ? logic'($urandom_range(1)) : logic'(fill == SDA_HIGH);
    endfunction

    // one request, then ticks until the engine is back to idle; with noise some ticks
    // carry stray requests or the unused command
    task automatic do_access(input logic [S_TUSER_W-1:0] cmd,
                             input logic [ADDR_W-1:0]    addr,
                             input logic [DATA_BITS-1:0] wdata,
                             input int                   sda_fill,
                             input bit                   with_noise);
        logic [S_TUSER_W-1:0] c;
        send_word(cmd, addr, wdata, pick_sda(sda_fill));
        while (eng_phase != PH_IDLE) begin
            c = CMD_TICK;
            if (with_noise && $urandom_range(7) == 0)
                c = S_TUSER_W'($urandom_range(3));
            send_word(c, ADDR_W'($urandom_range(127)), DATA_BITS'($urandom_range(16'hffff)),
                      pick_sda(sda_fill));
        end
    endtask

    // stop offering words until every booked pin word has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (expected_pins.size() != 0);
    endtask

    // register write with the engine idle and the stream empty
    task automatic set_half_period(input logic [TICK_W-1:0] value);
        while (eng_phase != PH_IDLE)
            send_random(CMD_TICK);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        hp_reg     = value;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] word %0d: %s", $realtime, words_checked, msg);
    endtask

    task automatic check_field(input string name, input logic [DATA_BITS-1:0] want,
                               input logic [DATA_BITS-1:0] got);
        if (want != got)
            report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    // tdata: scl[0], sda_out[1], sda_drive[2], cs_n[3], busy_res[4], read_data[20:5]
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pins.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %06h", m_axis_tdata));
                end else begin
                    want = expected_pins.pop_front();
                    check_field("scl", DATA_BITS'(want.scl), DATA_BITS'(m_axis_tdata[0]));
                    check_field("sda_out", DATA_BITS'(want.sda_out),
                                DATA_BITS'(m_axis_tdata[1]));
                    check_field("sda_drive", DATA_BITS'(want.sda_drive),
                                DATA_BITS'(m_axis_tdata[2]));
                    check_field("cs_n", DATA_BITS'(want.cs_n), DATA_BITS'(m_axis_tdata[3]));
                    check_field("busy_res", DATA_BITS'(want.busy_res),
                                DATA_BITS'(m_axis_tdata[4]));
                    check_field("read_data", want.read_data, m_axis_tdata[20:5]);
                    check_field("pad bits", '0, DATA_BITS'(m_axis_tdata[23:21]));
                    check_field("done_res", DATA_BITS'(want.done_res),
                                DATA_BITS'(m_axis_tlast));
                end
                words_checked++;
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // half period straight out of reset, one read covers send, gap and receive
    task automatic test_reset_default();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        do_access(CMD_READ, 7'h2a, 16'hc3a5, SDA_RANDOM, 1'b1);
    endtask

    // write frames with extreme address and data, then one with stray requests
    task automatic test_write_frames();
        src_idle_pct   = 31;
        sink_stall_pct = 31;
        set_half_period(8'd1);
        do_access(CMD_WRITE, 7'h00, 16'h0000, SDA_LOW, 1'b0);
        do_access(CMD_WRITE, 7'h7f, 16'hffff, SDA_HIGH, 1'b0);
        do_access(CMD_WRITE, ADDR_W'($urandom_range(127)),
                  DATA_BITS'($urandom_range(16'hffff)), SDA_RANDOM, 1'b1);
    endtask

    // reads returning all ones, all zeros, and random bits with stray requests
    task automatic test_read_frames();
        set_half_period(8'd1);
        do_access(CMD_READ, 7'h7f, DATA_BITS'($urandom_range(16'hffff)), SDA_HIGH, 1'b0);
        do_access(CMD_READ, 7'h00, DATA_BITS'($urandom_range(16'hffff)), SDA_LOW, 1'b0);
        do_access(CMD_READ, ADDR_W'($urandom_range(127)),
                  DATA_BITS'($urandom_range(16'hffff)), SDA_RANDOM, 1'b1);
    endtask

    // unused command on an idle engine does nothing
    task automatic test_unused_command();
        repeat (3)
            send_random(CMD_UNUSED);
    endtask

    // a request landing on the done tick is dropped, the next one starts back to back
    task automatic test_request_on_done();
        logic [S_TUSER_W-1:0] first;
        logic [S_TUSER_W-1:0] second;
        for (int k = 0; k < 2; k++) begin
            first  = k ? CMD_WRITE : CMD_READ;
            second = k ? CMD_READ : CMD_WRITE;
            send_random(first);
            while (eng_phase != PH_DONE)
                send_random(CMD_TICK);
            send_random(second);
            do_access(second, ADDR_W'($urandom_range(127)),
                      DATA_BITS'($urandom_range(16'hffff)), SDA_RANDOM, 1'b0);
        end
    endtask

    // zero in the register runs like one
    task automatic test_zero_half_period();
        set_half_period(8'd0);
        do_access(CMD_WRITE, ADDR_W'($urandom_range(127)),
                  DATA_BITS'($urandom_range(16'hffff)), SDA_RANDOM, 1'b0);
        do_access(CMD_READ, ADDR_W'($urandom_range(127)),
                  DATA_BITS'($urandom_range(16'hffff)), SDA_RANDOM, 1'b0);
    endtask

    // mostly whole accesses with random content, some loose words in between
    task automatic run_traffic(input int n_words);
        int stop_at;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            if ($urandom_range(7) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_random(S_TUSER_W'($urandom_range(3)));
            end else begin
                do_access($urandom_range(1) ? CMD_READ : CMD_WRITE,
                          ADDR_W'($urandom_range(127)),
                          DATA_BITS'($urandom_range(16'hffff)), SDA_RANDOM, 1'b1);
                repeat ($urandom_range(2))
                    send_random(CMD_TICK);
            end
        end
    endtask

    // random traffic under each idling pattern, short half periods keep accesses quick
    task automatic test_random_traffic();
        int src_pct[4]  = '{0, 64, 0, 31};
        int sink_pct[4] = '{0, 0, 64, 31};
        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            set_half_period(TICK_W'($urandom_range(1, 2)));
            run_traffic(40);
        end
    endtask

    initial begin
        reset_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_default();
        test_write_frames();
        test_read_frames();
        test_unused_command();
        test_request_on_done();
        test_zero_half_period();
        test_random_traffic();

        // let everything drain, then watch for stray words a little longer
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_three_wire_register_access_master_unit passed");
        else
            $display("tb_three_wire_register_access_master_unit failed");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #4000000;
        $display("tb_three_wire_register_access_master_unit failed");
        $finish;
    end

endmodule
